@@ hdl/rcr_pkg.sv @@
// ============================================================================
// rcr_pkg
// Shared types and constants for the RGB565 center-crop / resize block.
// ============================================================================
package rcr_pkg;

    localparam int PIX_W       = 16;   // RGB565 word
    localparam int IDX_W       = 14;   // tensor pixel index
    localparam int DIM_W       = 12;   // source dimension registers
    localparam int POS_W       = 11;   // source row / column position
    localparam int CHAN_W      = 8;    // one int8 channel
    localparam int OUT_TDATA_W = 40;   // 3 x 8 + 14, padded to bytes
    localparam int CFG_IDX_W   = 1;

    // step sizes by reciprocal multiplication: exact for any side below
    // 2^DIM_W and any output size up to 128
    localparam int RECIP_SH     = DIM_W + 8;
    localparam int RECIP_W      = RECIP_SH + 1;
    localparam int PROD_W       = DIM_W + RECIP_W;
    localparam int SETTLE_CYC   = 3;    // side, quotient, remainder stages
    localparam int SETTLE_CNT_W = 2;

    localparam int MAX_DIM     = 2048;

    localparam int OUT_WIDTH_DEF  = 96;
    localparam int OUT_HEIGHT_DEF = 96;

    localparam int SRC_WIDTH_RST  = 320;
    localparam int SRC_HEIGHT_RST = 240;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // frame geometry derived from the dimension registers
    typedef struct packed {
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] h_eff;
        logic [POS_W-1:0] off_x;
        logic [POS_W-1:0] off_y;
        logic [DIM_W-1:0] step_x;   // side / OUT_WIDTH
        logic [DIM_W-1:0] step_y;   // side / OUT_HEIGHT
        logic             busy;     // step values being recomputed
    } rcr_geom_t;

    // one selected pixel on its way to the output stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] index;
        logic             last;
    } rcr_item_t;

endpackage

@@ hdl/rcr_geom.sv @@
// ============================================================================
// rcr_geom
// Dimension registers, crop geometry and the nearest-neighbor step sizes,
// found by reciprocal multiplication in a short register pipeline.
// ============================================================================
module rcr_geom #(
    parameter int OUT_WIDTH  = rcr_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = rcr_pkg::OUT_HEIGHT_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [rcr_pkg::DIM_W-1:0]                 cfg_data,
    output rcr_pkg::rcr_geom_t                        geom,
    output logic [$clog2(OUT_WIDTH+1)-1:0]            rem_x,
    output logic [$clog2(OUT_HEIGHT+1)-1:0]           rem_y
);
    import rcr_pkg::*;

    localparam int RXW = $clog2(OUT_WIDTH + 1);
    localparam int RYW = $clog2(OUT_HEIGHT + 1);

    localparam int RST_SIDE = (SRC_WIDTH_RST < SRC_HEIGHT_RST) ? SRC_WIDTH_RST
                                                                : SRC_HEIGHT_RST;
    localparam logic [DIM_W-1:0] RST_QX = DIM_W'(RST_SIDE / OUT_WIDTH);
    localparam logic [DIM_W-1:0] RST_QY = DIM_W'(RST_SIDE / OUT_HEIGHT);
    localparam logic [RXW-1:0]   RST_RX = RXW'(RST_SIDE % OUT_WIDTH);
    localparam logic [RYW-1:0]   RST_RY = RYW'(RST_SIDE % OUT_HEIGHT);

    localparam logic [RECIP_W-1:0] RECIP_X =
        RECIP_W'(((1 << RECIP_SH) + OUT_WIDTH - 1) / OUT_WIDTH);
    localparam logic [RECIP_W-1:0] RECIP_Y =
        RECIP_W'(((1 << RECIP_SH) + OUT_HEIGHT - 1) / OUT_HEIGHT);
    localparam logic [DIM_W-1:0]   DIV_X   = DIM_W'(OUT_WIDTH);
    localparam logic [DIM_W-1:0]   DIV_Y   = DIM_W'(OUT_HEIGHT);

    logic [DIM_W-1:0]        src_w_reg;
    logic [DIM_W-1:0]        src_h_reg;
    logic [DIM_W-1:0]        w_eff;
    logic [DIM_W-1:0]        h_eff;
    logic [DIM_W-1:0]        side;

    logic [SETTLE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]        side_reg;
    logic [DIM_W-1:0]        qx_reg, qx_next;
    logic [DIM_W-1:0]        qy_reg, qy_next;
    logic [RXW-1:0]          rx_reg, rx_next;
    logic [RYW-1:0]          ry_reg, ry_next;
    logic [PROD_W-1:0]       prod_x;
    logic [PROD_W-1:0]       prod_y;
    logic [DIM_W-1:0]        qdx;
    logic [DIM_W-1:0]        qdy;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= DIM_W'(SRC_WIDTH_RST);
            src_h_reg <= DIM_W'(SRC_HEIGHT_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                default:           src_w_reg <= src_w_reg;
            endcase
        end
    end

    always_comb
    begin
        w_eff = clamp_dim(src_w_reg);
        h_eff = clamp_dim(src_h_reg);
        side  = (w_eff < h_eff) ? w_eff : h_eff;
    end

    // side is registered, then quotient = side * ceil(2^SH / N) >> SH,
    // then remainder = side - quotient * N; busy stays high after a write until these are valid
    always_comb
    begin
        prod_x  = PROD_W'(side_reg) * PROD_W'(RECIP_X);
        prod_y  = PROD_W'(side_reg) * PROD_W'(RECIP_Y);
        qx_next = prod_x[RECIP_SH +: DIM_W];
        qy_next = prod_y[RECIP_SH +: DIM_W];
        qdx     = qx_reg * DIV_X;
        qdy     = qy_reg * DIV_Y;
        rx_next = RXW'(side_reg - qdx);
        ry_next = RYW'(side_reg - qdy);
        if (cfg_we)
        begin
            cnt_next = SETTLE_CNT_W'(SETTLE_CYC);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - SETTLE_CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            side_reg <= DIM_W'(RST_SIDE);
            qx_reg   <= RST_QX;
            qy_reg   <= RST_QY;
            rx_reg   <= RST_RX;
            ry_reg   <= RST_RY;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            side_reg <= side;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
        end
    end

    always_comb
    begin
        geom.w_eff  = w_eff;
        geom.h_eff  = h_eff;
        geom.off_x  = POS_W'((w_eff - side) >> 1);
        geom.off_y  = POS_W'((h_eff - side) >> 1);
        geom.step_x = qx_reg;
        geom.step_y = qy_reg;
        geom.busy   = (cnt_reg != '0);
        rem_x       = rx_reg;
        rem_y       = ry_reg;
    end

endmodule

@@ hdl/rcr_front.sv @@
// ============================================================================
// rcr_front
// Raster position tracking and pixel selection: decides which source
// pixels land in the output tensor and queues them.
// ============================================================================
module rcr_front #(
    parameter int OUT_WIDTH  = rcr_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = rcr_pkg::OUT_HEIGHT_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      restart,
    input  rcr_pkg::rcr_geom_t                        geom,
    input  logic [$clog2(OUT_WIDTH+1)-1:0]            rem_x,
    input  logic [$clog2(OUT_HEIGHT+1)-1:0]           rem_y,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [rcr_pkg::PIX_W-1:0]                 s_tdata,
    input  logic                                      s_tuser,
    input  logic                                      q_room,
    output logic                                      q_push,
    output rcr_pkg::rcr_item_t                        q_item
);
    import rcr_pkg::*;

    localparam int OXW = $clog2(OUT_WIDTH + 1);
    localparam int OYW = $clog2(OUT_HEIGHT + 1);

    localparam logic [OXW-1:0] OX_END  = OXW'(OUT_WIDTH);
    localparam logic [OXW-1:0] OX_LAST = OXW'(OUT_WIDTH - 1);
    localparam logic [OYW-1:0] OY_END  = OYW'(OUT_HEIGHT);
    localparam logic [OYW-1:0] OY_LAST = OYW'(OUT_HEIGHT - 1);
    localparam logic [OXW:0]   RX_DIV  = (OXW+1)'(OUT_WIDTH);
    localparam logic [OYW:0]   RY_DIV  = (OYW+1)'(OUT_HEIGHT);
    localparam logic [IDX_W-1:0] ROW_STRIDE = IDX_W'(OUT_WIDTH);

    logic [POS_W-1:0] scol_reg, scol_next, scol_c;
    logic [POS_W-1:0] srow_reg, srow_next, srow_c;
    logic [OXW-1:0]   ox_reg,   ox_next,   ox_c;
    logic [OYW-1:0]   oy_reg,   oy_next,   oy_c;
    // targets are kept relative to the crop offsets
    logic [DIM_W-1:0] tcol_reg, tcol_next, tcol_c;
    logic [DIM_W-1:0] trow_reg, trow_next, trow_c;
    logic [OXW-1:0]   crem_reg, crem_next, crem_c;
    logic [OYW-1:0]   rrem_reg, rrem_next, rrem_c;
    logic [IDX_W-1:0] base_reg, base_next, base_c;

    logic             accept;
    logic             start;
    logic [DIM_W-1:0] tgt_x;
    logic [DIM_W-1:0] tgt_y;
    logic             row_hit;
    logic             hit;
    logic             col_last;
    logic             row_last;
    logic [OXW:0]     csum;
    logic [OYW:0]     rsum;
    logic             ccarry;
    logic             rcarry;

    assign s_tready = !geom.busy && q_room;

    always_comb
    begin
        accept = s_tvalid && s_tready;
        start  = s_tuser;

        // frame start reloads the state before this pixel is looked at
        scol_c = start ? '0 : scol_reg;
        srow_c = start ? '0 : srow_reg;
        ox_c   = start ? '0 : ox_reg;
        oy_c   = start ? '0 : oy_reg;
        tcol_c = start ? '0 : tcol_reg;
        trow_c = start ? '0 : trow_reg;
        crem_c = start ? '0 : crem_reg;
        rrem_c = start ? '0 : rrem_reg;
        base_c = start ? '0 : base_reg;

        tgt_x   = DIM_W'(geom.off_x) + tcol_c;
        tgt_y   = DIM_W'(geom.off_y) + trow_c;
        row_hit = ({1'b0, srow_c} == tgt_y) && (oy_c < OY_END);
        hit     = row_hit && (ox_c < OX_END) && ({1'b0, scol_c} == tgt_x);

        col_last = (DIM_W'(scol_c) + DIM_W'(1)) >= geom.w_eff;
        row_last = (DIM_W'(srow_c) + DIM_W'(1)) >= geom.h_eff;

        csum   = {1'b0, crem_c} + {1'b0, rem_x};
        ccarry = (csum >= RX_DIV);
        rsum   = {1'b0, rrem_c} + {1'b0, rem_y};
        rcarry = (rsum >= RY_DIV);

        scol_next = scol_c;
        srow_next = srow_c;
        ox_next   = ox_c;
        oy_next   = oy_c;
        tcol_next = tcol_c;
        trow_next = trow_c;
        crem_next = crem_c;
        rrem_next = rrem_c;
        base_next = base_c;

        if (hit)
        begin
            ox_next   = ox_c + OXW'(1);
            tcol_next = tcol_c + geom.step_x + DIM_W'(ccarry);
            crem_next = ccarry ? OXW'(csum - RX_DIV) : csum[OXW-1:0];
        end

        if (col_last)
        begin
            if (row_last)
            begin
                // frame wrap
                scol_next = '0;
                srow_next = '0;
                ox_next   = '0;
                oy_next   = '0;
                tcol_next = '0;
                trow_next = '0;
                crem_next = '0;
                rrem_next = '0;
                base_next = '0;
            end
            else
            begin
                if (row_hit)
                begin
                    oy_next   = oy_c + OYW'(1);
                    ox_next   = '0;
                    tcol_next = '0;
                    crem_next = '0;
                    trow_next = trow_c + geom.step_y + DIM_W'(rcarry);
                    rrem_next = rcarry ? OYW'(rsum - RY_DIV) : rsum[OYW-1:0];
                    base_next = base_c + ROW_STRIDE;
                end
                scol_next = '0;
                srow_next = srow_c + POS_W'(1);
            end
        end
        else
        begin
            scol_next = scol_c + POS_W'(1);
        end

        q_push       = accept && hit;
        q_item.pixel = s_tdata;
        q_item.index = base_c + IDX_W'(ox_c);
        q_item.last  = (oy_c == OY_LAST) && (ox_c == OX_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scol_reg <= '0;
            srow_reg <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            crem_reg <= '0;
            rrem_reg <= '0;
            base_reg <= '0;
        end
        else if (restart)
        begin
            scol_reg <= '0;
            srow_reg <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            crem_reg <= '0;
            rrem_reg <= '0;
            base_reg <= '0;
        end
        else if (accept)
        begin
            scol_reg <= scol_next;
            srow_reg <= srow_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            tcol_reg <= tcol_next;
            trow_reg <= trow_next;
            crem_reg <= crem_next;
            rrem_reg <= rrem_next;
            base_reg <= base_next;
        end
    end

endmodule

@@ hdl/rcr_fifo.sv @@
// ============================================================================
// rcr_fifo
// Short queue of selected pixels between the selection and output stages.
// ============================================================================
module rcr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rcr_pkg::rcr_item_t push_item,
    output logic               room,
    input  logic               pop,
    output logic               not_empty,
    output rcr_pkg::rcr_item_t pop_item
);
    import rcr_pkg::*;

    rcr_item_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign room      = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && room;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/rcr_back.sv @@
// ============================================================================
// rcr_back
// Output stage: RGB565 to offset int8 conversion and the output register.
// ============================================================================
module rcr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  rcr_pkg::rcr_item_t                q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rcr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import rcr_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - 3 * CHAN_W - IDX_W;

    logic                     valid_reg;
    logic signed [CHAN_W-1:0] red_reg,   red_next;
    logic signed [CHAN_W-1:0] green_reg, green_next;
    logic signed [CHAN_W-1:0] blue_reg,  blue_next;
    logic [IDX_W-1:0]         index_reg;
    logic                     last_reg;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    // widen by left shift, then subtracting 128 just flips the top bit
    always_comb
    begin
        red_next   = {~q_item.pixel[15], q_item.pixel[14:11], 3'b000};
        green_next = {~q_item.pixel[10], q_item.pixel[9:5],   2'b00};
        blue_next  = {~q_item.pixel[4],  q_item.pixel[3:0],   3'b000};
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            index_reg <= q_item.index;
            last_reg  <= q_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, index_reg, blue_reg, green_reg, red_reg};
    assign m_tlast  = last_reg;

endmodule

@@ hdl/rgb565_crop_resize_to_int8.sv @@
// ============================================================================
// rgb565_crop_resize_to_int8
// Center square crop and nearest-neighbor resize of an RGB565 pixel stream
// into an int8 HWC tensor of OUT_HEIGHT x OUT_WIDTH pixels.
// ============================================================================
// Usage:
//   s_* carries camera pixels in raster order, one transaction per pixel;
//   s_tuser high marks the first pixel of a frame. m_* carries one
//   transaction per selected pixel; m_tlast marks the last tensor pixel.
//   Source frame size is set through cfg_we / cfg_index / cfg_data; a write
//   restarts the frame state.
// Throughput: one pixel per cycle, sustained, with s_tready held high as
//   long as the output side keeps taking results and no step recompute is in progress.
// A selected pixel is picked combinationally and written into a two-entry
//   queue as its input transaction is accepted, then moves into the output
//   register that drives m_*.
// Reset / configuration: reset loads a 320 x 240 source. After a register
//   write the step sizes are recomputed in a three-stage pipeline; s_tready
//   stays low until the new values have settled.
// Back-pressure: when m_tready is low the queue fills, then s_tready drops;
//   no pixel or result is lost.
// ============================================================================
module rgb565_crop_resize_to_int8 #(
    parameter int OUT_WIDTH  = rcr_pkg::OUT_WIDTH_DEF,
    parameter int OUT_HEIGHT = rcr_pkg::OUT_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcr_pkg::DIM_W-1:0]         cfg_data,
    // pixel input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rcr_pkg::PIX_W-1:0]         s_tdata,   // pixel_word
    input  logic                              s_tuser,   // frame_start
    // tensor output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // red_value[7:0], green_value[15:8], blue_value[23:16],
    // tensor_pixel_index[37:24], zero pad[39:38]
    output logic [rcr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast    // frame_end
);
    import rcr_pkg::*;

    rcr_geom_t                     geom;
    logic [$clog2(OUT_WIDTH+1)-1:0]  rem_x;
    logic [$clog2(OUT_HEIGHT+1)-1:0] rem_y;
    logic                          q_room;
    logic                          q_push;
    rcr_item_t                     push_item;
    logic                          q_pop;
    logic                          q_valid;
    rcr_item_t                     pop_item;

    rcr_geom #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom),
        .rem_x     (rem_x),
        .rem_y     (rem_y)
    );

    rcr_front #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_we),
        .geom     (geom),
        .rem_x    (rem_x),
        .rem_y    (rem_y),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_room   (q_room),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rcr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .room      (q_room),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    rcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ tb/sv/rgb565_crop_resize_to_int8_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// rgb565_crop_resize_to_int8_tb
// Self-checking bench for the RGB565 center-crop / nearest-neighbor resize
// block. Source pixels are pushed through the stream input with random
// gaps. A local frame-walk predictor works out every selected tensor pixel,
// and each output transaction is checked against the oldest expected pixel.
// A short table of hand-picked pixels and register writes runs first,
// followed by a stall-free stretch and a set of random frame geometries.
// ============================================================================
module rgb565_crop_resize_to_int8_tb;

    import rcr_pkg::*;

    localparam int OUT_W        = OUT_WIDTH_DEF;
    localparam int OUT_H        = OUT_HEIGHT_DEF;
    localparam int CFG_SETTLE   = 16;           // step recompute time plus slack
    localparam int RUN_LIMIT_NS = 8_000_000;
    localparam int MAX_REPORTS  = 10;
    localparam int STEADY_ITEMS = 200;
    localparam int RANDOM_ITEMS = 576;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [IDX_W-1:0]  index;
        logic              last;
    } tensor_px_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [PIX_W-1:0]   data;       // pixel word, or register value
        logic               sof;
        logic               has_want;
        tensor_px_t         want;
    } dir_row_t;

    localparam tensor_px_t NO_PX = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata;    // pixel_word
    logic                   s_tuser;    // frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // red_value[7:0], green_value[15:8], blue_value[23:16],
    // tensor_pixel_index[37:24], zero pad[39:38]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;    // frame_end

    // predictor state
    logic [DIM_W-1:0]  frame_w_reg;
    logic [DIM_W-1:0]  frame_h_reg;
    logic [POS_W-1:0]  src_col;
    logic [POS_W-1:0]  src_row;
    logic [6:0]        out_col;
    logic [6:0]        out_row;
    logic [POS_W-1:0]  tgt_col;
    logic [POS_W-1:0]  tgt_row;

    tensor_px_t pending_pixels[$];
    bit         steady = 1'b0;
    int         error_count = 0;
    int         pixels_sent = 0;
    int         results_checked = 0;
    int         frame_ends = 0;
    int         reg_writes = 0;

    // 1x1 frames select every pixel as tensor index 0, so their channels
    // can be read straight off the pixel word
    dir_row_t dir_table [24] = '{
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h3C71, 1'b1, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hC38E, 1'b0, 1'b0, NO_PX},
        '{ROW_WRITE, REG_SOURCE_WIDTH,  16'd0,    1'b0, 1'b0, NO_PX},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 16'd0,    1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h0000, 1'b1, 1'b1,
          '{8'h80, 8'h80, 8'h80, 14'd0, 1'b0}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hFFFF, 1'b0, 1'b1,
          '{8'h78, 8'h7C, 8'h78, 14'd0, 1'b0}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hF800, 1'b0, 1'b1,
          '{8'h78, 8'h80, 8'h80, 14'd0, 1'b0}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h07E0, 1'b0, 1'b1,
          '{8'h80, 8'h7C, 8'h80, 14'd0, 1'b0}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h001F, 1'b0, 1'b1,
          '{8'h80, 8'h80, 8'h78, 14'd0, 1'b0}},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h8410, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 14'd0, 1'b0}},
        // oversize width clamps to the maximum
        '{ROW_WRITE, REG_SOURCE_WIDTH,  16'd4095, 1'b0, 1'b0, NO_PX},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 16'd2048, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hA5A5, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h5A5A, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h1234, 1'b1, 1'b0, NO_PX},
        // 3x2 source: crop side below the tensor size, then frame wrap
        '{ROW_WRITE, REG_SOURCE_WIDTH,  16'd3,    1'b0, 1'b0, NO_PX},
        '{ROW_WRITE, REG_SOURCE_HEIGHT, 16'd2,    1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h6B2D, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h94D2, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h2F81, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hD07E, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h7777, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'h8888, 1'b0, 1'b0, NO_PX},
        '{ROW_PIXEL, REG_SOURCE_WIDTH,  16'hE31C, 1'b0, 1'b0, NO_PX}
    };

    rgb565_crop_resize_to_int8 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // frame-walk predictor
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    function automatic int unsigned square_side();
        int unsigned w;
        int unsigned h;
        w = clamp_dim(frame_w_reg);
        h = clamp_dim(frame_h_reg);
        return (w < h) ? w : h;
    endfunction

    function automatic int unsigned crop_off_x();
        return (clamp_dim(frame_w_reg) - square_side()) / 2;
    endfunction

    function automatic int unsigned crop_off_y();
        return (clamp_dim(frame_h_reg) - square_side()) / 2;
    endfunction

    function automatic void restart_counters();
        src_col = '0;
        src_row = '0;
        out_col = '0;
        out_row = '0;
        tgt_col = POS_W'(crop_off_x());
        tgt_row = POS_W'(crop_off_y());
    endfunction

    // advances the frame walk by one source pixel; returns 1 when the pixel
    // lands on the next tensor position
    function automatic bit sample_source_pixel(input logic [PIX_W-1:0] pix,
                                               input logic sof,
                                               output tensor_px_t px);
        int unsigned w;
        int unsigned h;
        int unsigned side;
        bit          hit;
        bit          sampled_row;
        w   = clamp_dim(frame_w_reg);
        h   = clamp_dim(frame_h_reg);
        hit = 1'b0;
        px  = '0;
        if (sof)
            restart_counters();
        side = square_side();
        if (out_row < OUT_H && out_col < OUT_W && src_row == tgt_row && src_col == tgt_col)
        begin
            px.red   = {pix[15:11], 3'b000} ^ 8'h80;
            px.green = {pix[10:5], 2'b00} ^ 8'h80;
            px.blue  = {pix[4:0], 3'b000} ^ 8'h80;
            px.index = IDX_W'(out_row * OUT_W + out_col);
            px.last  = (out_row == OUT_H - 1) && (out_col == OUT_W - 1);
            hit      = 1'b1;
            out_col  = out_col + 7'd1;
            if (out_col < OUT_W)
                tgt_col = POS_W'(crop_off_x() + (out_col * side) / OUT_W);
        end
        if (src_col + 1 >= w)
        begin
            sampled_row = (src_row == tgt_row) && (out_row < OUT_H);
            if (src_row + 1 >= h)
            begin
                restart_counters();
                return hit;
            end
            if (sampled_row)
            begin
                out_row = out_row + 7'd1;
                out_col = '0;
                tgt_col = POS_W'(crop_off_x());
                if (out_row < OUT_H)
                    tgt_row = POS_W'(crop_off_y() + (out_row * side) / OUT_H);
            end
            src_col = '0;
            src_row = src_row + POS_W'(1);
        end
        else
        begin
            src_col = src_col + POS_W'(1);
        end
        return hit;
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic string px_text(input tensor_px_t px);
        return $sformatf("r=%0d g=%0d b=%0d idx=%0d last=%0b", $signed(px.red),
                         $signed(px.green), $signed(px.blue), px.index, px.last);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                              input bit has_want, input tensor_px_t want);
        tensor_px_t px;
        bit         hit;
        while (!steady && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        do
            @(posedge clk);
        while (!s_tready);
        hit = sample_source_pixel(pix, sof, px);
        if (has_want)
            pending_pixels.push_back(want);
        else if (hit)
            pending_pixels.push_back(px);
        pixels_sent++;
    endtask

    // hold the input until every selected pixel has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SOURCE_WIDTH)
            frame_w_reg = value;
        else
            frame_h_reg = value;
        restart_counters();
        reg_writes++;
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int unsigned n_pix, input bit lead_sof,
                             input int unsigned noise_pct, input int unsigned pause_at,
                             input int unsigned quiet_from, input int unsigned quiet_to);
        logic sof;
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        for (int unsigned i = 0; i < n_pix; i++)
        begin
            if (i == pause_at)
                drain_results();
            steady = (i >= quiet_from) && (i < quiet_to);
            sof = (i == 0) ? lead_sof : ($urandom_range(99) < noise_pct);
            send_pixel(PIX_W'($urandom_range(16'hFFFF)), sof, 1'b0, NO_PX);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 34);

    always @(posedge clk)
    begin
        tensor_px_t got;
        tensor_px_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[37:24], m_tlast};
            if (pending_pixels.size() == 0)
            begin
                note_error({"unexpected tensor pixel: ", px_text(got)});
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.index !== want.index ||
                    got.last !== want.last)
                    note_error({"tensor pixel mismatch: expected ", px_text(want),
                                ", got ", px_text(got)});
            end
            results_checked++;
            if (got.last)
                frame_ends++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned      random_items;
        int unsigned      shape;
        int unsigned      n_pix;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        frame_w_reg = DIM_W'(SRC_WIDTH_RST);
        frame_h_reg = DIM_W'(SRC_HEIGHT_RST);
        restart_counters();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[k])
        begin
            if (dir_table[k].kind == ROW_WRITE)
                write_reg(dir_table[k].reg_idx, dir_table[k].data[DIM_W-1:0]);
            else
                send_pixel(dir_table[k].data, dir_table[k].sof, dir_table[k].has_want,
                           dir_table[k].want);
        end

        // first source row of a wide frame with no idling on either side:
        // source pixels go in back to back
        run_phase(12'd200, 12'd150, STEADY_ITEMS, 1'b1, 0, STEADY_ITEMS, 0, STEADY_ITEMS);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            shape = $urandom_range(9);
            if (shape < 3)
            begin
                w     = DIM_W'($urandom_range(12));
                h     = DIM_W'($urandom_range(12));
                n_pix = $urandom_range(20, 80);
            end
            else if (shape < 8)
            begin
                w     = DIM_W'($urandom_range(96, 240));
                h     = DIM_W'($urandom_range(96, 240));
                n_pix = $urandom_range(100, 300);
            end
            else
            begin
                w     = DIM_W'($urandom_range(4095));
                h     = DIM_W'($urandom_range(4095));
                n_pix = $urandom_range(30, 100);
            end
            if (n_pix > RANDOM_ITEMS - random_items)
                n_pix = RANDOM_ITEMS - random_items;
            run_phase(w, h, n_pix, $urandom_range(3) != 0, 2,
                      ($urandom_range(4) == 0) ? n_pix / 2 : n_pix, 0, 0);
            random_items += n_pix;
        end

        drain_results();
        if (pending_pixels.size() != 0)
            note_error($sformatf("%0d tensor pixels never arrived", pending_pixels.size()));

        $display("Sent %0d source pixels, checked %0d tensor pixels, %0d complete tensors",
                 pixels_sent, results_checked, frame_ends);
        $display("Register writes: %0d, errors: %0d", reg_writes, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d tensor pixels still pending", pending_pixels.size());
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rcr_pkg.sv
hdl/rcr_geom.sv
hdl/rcr_front.sv
hdl/rcr_fifo.sv
hdl/rcr_back.sv
hdl/rgb565_crop_resize_to_int8.sv
tb/sv/rgb565_crop_resize_to_int8_tb.sv
